// File: rtl/spq_pkg.sv
// Shared types and constants for the stable priority task queue.
// Used by spq_cell and stable_priority_task_queue_unit; depends on nothing.
package spq_pkg;

  localparam int PRI_BITS = 8;
  localparam int TAG_BITS = 8;
  localparam int OCC_BITS = 5;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_SERVE  = 2'd2;

  typedef struct packed {
    logic [1:0]          func;
    logic [PRI_BITS-1:0] priority_req;
    logic [TAG_BITS-1:0] task_tag;
  } in_item_t;

  typedef struct packed {
    logic                served_valid;
    logic [TAG_BITS-1:0] served_tag;
    logic [PRI_BITS-1:0] served_priority;
    logic                remove_found;
    logic                insert_dropped;
    logic [OCC_BITS-1:0] occupancy;
  } out_item_t;

  // One queue entry as held by a cell.
  typedef struct packed {
    logic [PRI_BITS-1:0] pri_val;
    logic [TAG_BITS-1:0] tag_val;
  } entry_t;

  // What a cell loads at the next clock edge.
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_FROM_PREV,
    SEL_FROM_NEXT
  } cell_sel_t;

  // Local compare results a cell reports to the control logic.
  typedef struct packed {
    logic below;  // new priority is strictly higher, or the cell is empty
    logic hit;    // occupied and the tag matches
  } cell_flag_t;

endpackage

// File: rtl/spq_cell.sv
// One cell of the queue row: holds a single entry and compares it locally.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  logic       occupied,
  input  entry_t     new_i,
  input  entry_t     prev_i,
  input  entry_t     next_i,
  input  cell_sel_t  sel,
  output entry_t     entry_o,
  output cell_flag_t flag_o
);

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    unique case (sel)
      SEL_HOLD:      entry_nxt = entry_r;
      SEL_LOAD:      entry_nxt = new_i;
      SEL_FROM_PREV: entry_nxt = prev_i;
      SEL_FROM_NEXT: entry_nxt = next_i;
      default:       entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o      = entry_r;
  assign flag_o.below = !occupied || (new_i.pri_val > entry_r.pri_val);
  assign flag_o.hit   = occupied && (new_i.tag_val == entry_r.tag_val);

endmodule

// File: rtl/stable_priority_task_queue_unit.sv
// Top level of the stable priority task queue: a row of spq_cell instances
// plus occupancy tracking and the registered result. Depends on spq_pkg, spq_cell.
//
//  Channel  Ports                     Handshake
//  -------  ------------------------  -----------------------------------------
//  input    start, busy, in_item      item taken at a clock edge with start=1,
//                                     busy=0
//  result   out_strobe, out_item      item shown for one cycle, out_strobe=1
//
// All cells compare against the incoming item in parallel and shift or load
// in the same edge, so a new item is accepted every cycle and busy stays low.
// The result item appears on the cycle after acceptance and is valid only
// while out_strobe is high. Reset (rst_n low, synchronous) empties the queue;
// the stored entries themselves are not cleared since only occupied cells
// are ever read.
// The receiver cannot stall, so no result is ever held back.
module stable_priority_task_queue_unit import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Number of occupied cells; cells 0 to count-1 hold the queue in order.
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic      out_strobe_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  entry_t     cell_q   [QUEUE_DEPTH];
  cell_flag_t cell_flag[QUEUE_DEPTH];
  cell_sel_t  cell_sel [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] occupied;
  logic [QUEUE_DEPTH-1:0] below;
  logic [QUEUE_DEPTH-1:0] below_prev;
  logic [QUEUE_DEPTH-1:0] hit;
  logic [QUEUE_DEPTH-1:0] hit_first;
  logic [QUEUE_DEPTH-1:0] shift_up_mask;

  entry_t new_entry;
  logic   accept;
  logic   full;
  logic   empty;
  logic   found;
  logic   do_insert;
  logic   do_remove;
  logic   do_serve;

  // The block finishes every item in the cycle it is taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign new_entry.pri_val = in_item.priority_req;
  assign new_entry.tag_val = in_item.task_tag;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  // Occupancy as a thermometer code: cell i is live when i < count.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occupied[i] = (CNT_W'(i) < count_r);
    end
  end

  // Gather the per-cell compare flags into vectors.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      below[i] = cell_flag[i].below;
      hit[i]   = cell_flag[i].hit;
    end
  end

  // The queue is sorted by descending priority, so the "below" flags form a
  // contiguous run up to the end of the row; the new item lands at the first
  // cell of that run and every later cell takes its predecessor's entry.
  assign below_prev = {below[QUEUE_DEPTH-2:0], 1'b0};

  // A remove deletes the first matching entry. Isolating the lowest set bit
  // of the hit vector and subtracting one gives all cells ahead of it; the
  // complement is the run of cells that take their successor's entry.
  assign hit_first     = hit & (~hit + QUEUE_DEPTH'(1));
  assign shift_up_mask = ~(hit_first - QUEUE_DEPTH'(1));
  assign found         = |hit;

  assign do_insert = accept && (in_item.func == FUNC_INSERT) && !full;
  assign do_remove = accept && (in_item.func == FUNC_REMOVE) && found;
  assign do_serve  = accept && (in_item.func == FUNC_SERVE) && !empty;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_sel[i] = SEL_HOLD;
      if (do_insert && below[i]) begin
        cell_sel[i] = below_prev[i] ? SEL_FROM_PREV : SEL_LOAD;
      end else if (do_serve || (do_remove && shift_up_mask[i])) begin
        cell_sel[i] = SEL_FROM_NEXT;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove || do_serve) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // The served entry is whatever sits in the head cell before the shift.
  always_comb begin
    out_item_nxt.served_valid    = do_serve;
    out_item_nxt.served_tag      = do_serve ? cell_q[0].tag_val : '0;
    out_item_nxt.served_priority = do_serve ? cell_q[0].pri_val : '0;
    out_item_nxt.remove_found    = do_remove;
    out_item_nxt.insert_dropped  = accept && (in_item.func == FUNC_INSERT) && full;
    out_item_nxt.occupancy       = OCC_BITS'(count_nxt);
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;

      // The row ends feed back their own entry; the head's is never chosen, and the
      // tail's only when the tail cell is empty or is vacated by that shift.
      if (g == 0) begin : g_head
        assign prev_e = cell_q[g];
      end else begin : g_mid_prev
        assign prev_e = cell_q[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign next_e = cell_q[g];
      end else begin : g_mid_next
        assign next_e = cell_q[g+1];
      end

      spq_cell u_cell (
        .clk      (clk),
        .occupied (occupied[g]),
        .new_i    (new_entry),
        .prev_i   (prev_e),
        .next_i   (next_e),
        .sel      (cell_sel[g]),
        .entry_o  (cell_q[g]),
        .flag_o   (cell_flag[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// File: verif/tb_stable_priority_task_queue_unit.sv
// Self-checking testbench for stable_priority_task_queue_unit: directed and random
// insert, remove and serve items checked against an in-bench queue predictor.
// Depends on spq_pkg and the RTL of stable_priority_task_queue_unit.
module tb_stable_priority_task_queue_unit;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 16;
  // The package names three operations; the fourth selector value does nothing.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Cycles to keep watching after the last expected result has arrived.
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 600;
  localparam int MAX_REPORTS = 10;

  // Random items come in bursts that lean toward one kind of work, so the
  // queue is filled to the top, drained to empty and churned in between.
  typedef enum logic [1:0] {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED,
    BURST_PURGE
  } burst_kind_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  // Items waiting to be offered, and the results the queue owes us, oldest first.
  in_item_t  pending_items[$];
  out_item_t owed_results[$];

  // Shadow copy of the queue contents: slot 0 is the head.
  entry_t      shadow_slots[QUEUE_DEPTH];
  int unsigned shadow_count = 0;

  int total_items = 0;
  int accepted_count = 0;
  int mismatch_count = 0;

  stable_priority_task_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one operation to the shadow queue and returns the result item the
  // block must report for it. Insertion goes in front of the first entry of
  // strictly lower priority, which keeps equal priorities in arrival order.
  function automatic out_item_t apply_queue_op(in_item_t op);
    out_item_t res;
    int        pos;
    int        idx;
    logic      hit;
    res = '0;
    case (op.func)
      FUNC_INSERT: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          res.insert_dropped = 1'b1;
        end else begin
          pos = shadow_count;
          for (idx = shadow_count - 1; idx >= 0; idx--) begin
            if (op.priority_req > shadow_slots[idx].pri_val) pos = idx;
          end
          for (idx = shadow_count; idx > pos; idx--) shadow_slots[idx] = shadow_slots[idx-1];
          shadow_slots[pos].pri_val = op.priority_req;
          shadow_slots[pos].tag_val = op.task_tag;
          shadow_count++;
        end
      end
      FUNC_REMOVE: begin
        hit = 1'b0;
        pos = 0;
        for (idx = 0; idx < shadow_count; idx++) begin
          if (!hit && shadow_slots[idx].tag_val == op.task_tag) begin
            hit = 1'b1;
            pos = idx;
          end
        end
        if (hit) begin
          for (idx = pos; idx + 1 < shadow_count; idx++) shadow_slots[idx] = shadow_slots[idx+1];
          shadow_count--;
          res.remove_found = 1'b1;
        end
      end
      FUNC_SERVE: begin
        if (shadow_count > 0) begin
          res.served_valid    = 1'b1;
          res.served_tag      = shadow_slots[0].tag_val;
          res.served_priority = shadow_slots[0].pri_val;
          for (idx = 0; idx + 1 < shadow_count; idx++) shadow_slots[idx] = shadow_slots[idx+1];
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    res.occupancy = OCC_BITS'(shadow_count);
    return res;
  endfunction

  task automatic queue_op(logic [1:0] func, logic [PRI_BITS-1:0] pri, logic [TAG_BITS-1:0] tag);
    in_item_t op;
    op.func         = func;
    op.priority_req = pri;
    op.task_tag     = tag;
    pending_items.push_back(op);
  endtask

  // Draws one random item for the given burst kind. Tags come mostly from a
  // small pool so that removes often find a match and duplicate tags occur;
  // priorities come often from a few coarse levels so that ties are common.
  function automatic in_item_t random_op(burst_kind_t kind);
    in_item_t op;
    int       roll;
    roll = $urandom_range(99);
    case (kind)
      BURST_FILL:  op.func = (roll < 80) ? FUNC_INSERT : (roll < 90) ? FUNC_SERVE : FUNC_REMOVE;
      BURST_DRAIN: op.func = (roll < 70) ? FUNC_SERVE : (roll < 85) ? FUNC_REMOVE : FUNC_INSERT;
      BURST_PURGE: op.func = (roll < 60) ? FUNC_REMOVE : (roll < 80) ? FUNC_INSERT : FUNC_SERVE;
      default:     op.func = (roll < 40) ? FUNC_INSERT : (roll < 70) ? FUNC_SERVE : FUNC_REMOVE;
    endcase
    // A few unused selectors, which must leave the queue alone.
    if ($urandom_range(99) < 3) op.func = FUNC_UNUSED;
    if ($urandom_range(99) < 40) op.priority_req = PRI_BITS'($urandom_range(3) * 85);
    else op.priority_req = PRI_BITS'($urandom);
    if ($urandom_range(99) < 70) op.task_tag = TAG_BITS'($urandom_range(11));
    else op.task_tag = TAG_BITS'($urandom);
    return op;
  endfunction

  // Driver. An item is taken at an edge where start is high and busy is low;
  // at that same edge the predictor runs on it. Whenever the port is free the
  // next item is either offered or held back for an idle cycle. start is
  // assigned at most once per edge, so back-to-back items keep it high.
  always @(posedge clk) begin : drive_items
    int idle_pct;
    if (rst_n && start && !busy) begin
      owed_results.push_back(apply_queue_op(in_item));
      accepted_count++;
    end
    // Idle rate by stage of the run: light, then heavy, then none at all.
    if (accepted_count < total_items / 3) idle_pct = 9;
    else if (accepted_count < (2 * total_items) / 3) idle_pct = 62;
    else idle_pct = 0;
    if (rst_n && (!start || !busy)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_item <= pending_items.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Each strobed result is accepted at the edge that ends its cycle
  // and compared field by field with the oldest owed result.
  always @(posedge clk) begin : check_results
    out_item_t want;
    logic      differs;
    if (rst_n && out_strobe) begin
      if (owed_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result with nothing owed: valid=%0d tag=%02h pri=%02h found=%0d drop=%0d occ=%0d",
                   $realtime, out_item.served_valid, out_item.served_tag,
                   out_item.served_priority, out_item.remove_found,
                   out_item.insert_dropped, out_item.occupancy);
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        differs = (out_item.served_valid    !== want.served_valid)
               || (out_item.served_tag      !== want.served_tag)
               || (out_item.served_priority !== want.served_priority)
               || (out_item.remove_found    !== want.remove_found)
               || (out_item.insert_dropped  !== want.insert_dropped)
               || (out_item.occupancy       !== want.occupancy);
        if (differs) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: mismatch exp valid=%0d tag=%02h pri=%02h found=%0d drop=%0d occ=%0d, got valid=%0d tag=%02h pri=%02h found=%0d drop=%0d occ=%0d",
                     $realtime, want.served_valid, want.served_tag, want.served_priority,
                     want.remove_found, want.insert_dropped, want.occupancy,
                     out_item.served_valid, out_item.served_tag, out_item.served_priority,
                     out_item.remove_found, out_item.insert_dropped, out_item.occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : run_stimulus
    int          burst_len;
    int          k;
    int          random_count;
    burst_kind_t kind;

    // Every operation on an empty queue, including the unused selector.
    queue_op(FUNC_SERVE, 8'h00, 8'h00);
    queue_op(FUNC_REMOVE, 8'hFF, 8'h00);
    queue_op(FUNC_UNUSED, 8'hFF, 8'hFF);
    // Fill to the top with the extreme priorities, ties that must stay in
    // arrival order, and a repeated tag.
    queue_op(FUNC_INSERT, 8'h80, 8'h01);
    queue_op(FUNC_INSERT, 8'h80, 8'h02);
    queue_op(FUNC_INSERT, 8'hFF, 8'hFF);
    queue_op(FUNC_INSERT, 8'h00, 8'h00);
    queue_op(FUNC_INSERT, 8'h80, 8'h03);
    queue_op(FUNC_INSERT, 8'h00, 8'h04);
    queue_op(FUNC_INSERT, 8'hFF, 8'h05);
    queue_op(FUNC_INSERT, 8'h40, 8'h02);
    for (k = 8; k < QUEUE_DEPTH; k++) queue_op(FUNC_INSERT, PRI_BITS'(k * 17), TAG_BITS'(8'hA0 + k));
    // Insert into a full queue is dropped; the unused selector reports the count.
    queue_op(FUNC_INSERT, 8'hFF, 8'h77);
    queue_op(FUNC_UNUSED, 8'h00, 8'h00);
    // The repeated tag removes the entry nearest the head; a missing tag finds nothing.
    queue_op(FUNC_REMOVE, 8'h00, 8'h02);
    queue_op(FUNC_REMOVE, 8'h00, 8'h99);
    queue_op(FUNC_SERVE, 8'h00, 8'h00);
    queue_op(FUNC_SERVE, 8'hFF, 8'hFF);

    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      kind = burst_kind_t'($urandom_range(3));
      burst_len = $urandom_range(4, 24);
      for (k = 0; k < burst_len; k++) pending_items.push_back(random_op(kind));
      random_count += burst_len;
    end
    // Leave the queue empty at the end so serving an emptied queue and
    // inserting into it afterwards are always exercised.
    for (k = 0; k < QUEUE_DEPTH + 1; k++) queue_op(FUNC_SERVE, 8'h00, 8'h00);
    queue_op(FUNC_INSERT, 8'h5A, 8'hA5);
    queue_op(FUNC_SERVE, 8'h00, 8'h00);
    total_items = pending_items.size();

    // Synchronous reset, held low from time zero and released once.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_items || owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("tb_stable_priority_task_queue_unit passed");
    end else begin
      $display("tb_stable_priority_task_queue_unit failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #400000;
    $display("tb_stable_priority_task_queue_unit failed");
    $finish;
  end

endmodule
